/* src/pamn_pkg.sv */
// Shared constants, types and controller-to-datapath signal groups for the
// point attribute min-max normalizer. No dependencies.
package pamn_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = IDX_W + 1;

  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned NORM_W     = 17;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] REG_EN_LIGHT  = 3'd0;
  localparam logic [2:0] REG_EN_HEALTH = 3'd1;
  localparam logic [2:0] REG_EN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_EN_GEN    = 3'd3;
  localparam logic [2:0] REG_EPSILON   = 3'd4;

  localparam logic [1:0] CH_LIGHT  = 2'd0;
  localparam logic [1:0] CH_HEALTH = 2'd1;
  localparam logic [1:0] CH_HEIGHT = 2'd2;
  localparam logic [1:0] CH_GEN    = 2'd3;

  localparam logic [5:0] HEALTH_STEPS = 6'd32;
  localparam logic [5:0] NORM_STEPS   = 6'd16;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       hdiv_start;
    logic       load_commit;
    logic       mem_read;
    logic       norm_start;
    logic       norm_capture;
    logic [1:0] chan;
    logic       publish;
  } pamn_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } pamn_sts_t;

endpackage

/* src/pamn_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on pamn_pkg.
module pamn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [5:0]  steps_i,
  input  logic [32:0] rem_init_i,
  input  logic [31:0] dvd_init_i,
  input  logic [32:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);
  import pamn_pkg::*;

  logic [32:0] rem_q, rem_d, dsr_q;
  logic [31:0] dvd_q, quo_q;
  logic [5:0]  cnt_q;
  logic [33:0] trial;
  logic        ge;

  assign trial  = {rem_q, dvd_q[31]};
  assign ge     = trial >= {1'b0, dsr_q};
  assign rem_d  = ge ? 33'(trial - {1'b0, dsr_q}) : trial[32:0];
  assign busy_o = cnt_q != 6'd0;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      dvd_q <= dvd_init_i;
      dsr_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_o) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
  end

endmodule

/* src/pamn_ctrl.sv */
// Sequencing state machine: dispatches each transaction and drives the datapath.
// Depends on pamn_pkg.
module pamn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  pamn_pkg::pamn_sts_t sts_i,
  output pamn_pkg::pamn_cmd_t cmd_o
);
  import pamn_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_HWAIT  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_NSTART = 3'd4;
  localparam logic [2:0] S_NWAIT  = 3'd5;
  localparam logic [2:0] S_PUB    = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] act_q, act_d, chan_q, chan_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    chan_d  = chan_q;
    cmd_o   = '0;
    cmd_o.chan = chan_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          act_d   = action_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (act_q)
          ACT_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end
          ACT_LOAD: begin
            cmd_o.hdiv_start = 1'b1;
            state_d = S_HWAIT;
          end
          ACT_READ: begin
            cmd_o.mem_read = 1'b1;
            chan_d  = CH_LIGHT;
            state_d = S_NSTART;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_HWAIT: begin
        if (!sts_i.div_busy) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.load_commit = 1'b1;
        state_d = S_IDLE;
      end
      S_NSTART: begin
        cmd_o.norm_start = 1'b1;
        state_d = S_NWAIT;
      end
      S_NWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.norm_capture = 1'b1;
          if (chan_q == CH_GEN) begin
            state_d = S_PUB;
          end else begin
            chan_d  = chan_q + 2'd1;
            state_d = S_NSTART;
          end
        end
      end
      S_PUB: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_CLEAR;
      chan_q  <= CH_LIGHT;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      chan_q  <= chan_d;
    end
  end

endmodule

/* src/pamn_datapath.sv */
// Point stores, range tracking, configuration registers and output register.
// Depends on pamn_pkg and pamn_div.
module pamn_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pamn_pkg::pamn_cmd_t         cmd_i,
  output pamn_pkg::pamn_sts_t         sts_o,
  input  logic [pamn_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic                        cfg_valid_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pamn_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                        out_status_o
);
  import pamn_pkg::*;

  logic        en_l_q, en_h_q, en_z_q, en_g_q;
  logic [15:0] eps_q;

  logic [9:0]         pidx_q;
  logic signed [31:0] light_q, hz_q;
  logic [31:0]        eth_q;
  logic [15:0]        age_q, lsen_q, gen_q;

  logic signed [31:0] light_mem [MAX_POINTS];
  logic signed [31:0] health_mem [MAX_POINTS];
  logic signed [31:0] height_mem [MAX_POINTS];
  logic [15:0]        gen_mem [MAX_POINTS];

  logic [CNT_W-1:0]   count_q;
  logic               ovf_q;
  logic signed [31:0] lmin_q, lmax_q, hmin_q, hmax_q, zmin_q, zmax_q;
  logic [15:0]        gmin_q, gmax_q;

  logic signed [31:0] rl_q, rh_q, rz_q;
  logic [15:0]        rg_q;
  logic               rok_q;

  logic [NORM_W-1:0]  norm_q [4];
  logic               use_div_q;

  logic               oval_q;
  logic [OUT_DATA_W-1:0] odata_q;
  logic               ostat_q;

  logic [16:0]        hdivisor;
  logic signed [33:0] hx;
  logic signed [31:0] health;
  logic               full;

  logic signed [33:0] sp_l, sp_h, sp_z, sp_g, eps_x;
  logic               has_l, has_h, has_z, has_g;
  logic signed [33:0] v, lo, span, num;
  logic               has_c;

  logic               div_start, div_busy;
  logic [5:0]         div_steps;
  logic [32:0]        div_rem, div_dsr;
  logic [31:0]        div_dvd, quot;

  assign hdivisor = (age_q > lsen_q ? {1'b0, age_q} : {1'b0, lsen_q}) + 17'd1;
  assign hx       = 34'sd65536 - $signed({2'b0, quot});
  assign health   = (hx < -34'sd2147483648) ? 32'sh8000_0000 : hx[31:0];
  assign full     = count_q == CNT_W'(MAX_POINTS);

  assign eps_x = $signed({18'b0, eps_q});
  assign sp_l  = 34'(lmax_q) - 34'(lmin_q);
  assign sp_h  = 34'(hmax_q) - 34'(hmin_q);
  assign sp_z  = 34'(zmax_q) - 34'(zmin_q);
  assign sp_g  = $signed({18'b0, gmax_q}) - $signed({18'b0, gmin_q});
  assign has_l = en_l_q && (sp_l > eps_x);
  assign has_h = en_h_q && (sp_h > eps_x);
  assign has_z = en_z_q && (sp_z > eps_x);
  assign has_g = en_g_q && (gmax_q > gmin_q);

  always_comb begin
    case (cmd_i.chan)
      CH_LIGHT:  begin v = 34'(rl_q); lo = 34'(lmin_q); span = sp_l; has_c = has_l; end
      CH_HEALTH: begin v = 34'(rh_q); lo = 34'(hmin_q); span = sp_h; has_c = has_h; end
      CH_HEIGHT: begin v = 34'(rz_q); lo = 34'(zmin_q); span = sp_z; has_c = has_z; end
      default: begin
        v = $signed({18'b0, rg_q}); lo = $signed({18'b0, gmin_q}); span = sp_g; has_c = has_g;
      end
    endcase
    num = v - lo;
  end

  always_comb begin
    div_start = 1'b0;
    div_steps = HEALTH_STEPS;
    div_rem   = '0;
    div_dvd   = eth_q;
    div_dsr   = {16'b0, hdivisor};
    if (cmd_i.hdiv_start) begin
      div_start = 1'b1;
    end else if (cmd_i.norm_start) begin
      div_start = rok_q && has_c && (num > 34'sd0) && (num < span);
      div_steps = NORM_STEPS;
      div_rem   = num[32:0];
      div_dvd   = '0;
      div_dsr   = span[32:0];
    end
  end

  pamn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .rem_init_i (div_rem),
    .dvd_init_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !oval_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_l_q <= 1'b1;
      en_h_q <= 1'b1;
      en_z_q <= 1'b1;
      en_g_q <= 1'b1;
      eps_q  <= 16'd7;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EN_LIGHT:  en_l_q <= cfg_data_i[0];
        REG_EN_HEALTH: en_h_q <= cfg_data_i[0];
        REG_EN_HEIGHT: en_z_q <= cfg_data_i[0];
        REG_EN_GEN:    en_g_q <= cfg_data_i[0];
        REG_EPSILON:   eps_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pidx_q  <= in_data_i[9:0];
      light_q <= in_data_i[41:10];
      eth_q   <= in_data_i[73:42];
      age_q   <= in_data_i[89:74];
      lsen_q  <= in_data_i[105:90];
      hz_q    <= in_data_i[137:106];
      gen_q   <= in_data_i[153:138];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_commit && !full) begin
      light_mem[count_q[IDX_W-1:0]]  <= light_q;
      health_mem[count_q[IDX_W-1:0]] <= health;
      height_mem[count_q[IDX_W-1:0]] <= hz_q;
      gen_mem[count_q[IDX_W-1:0]]    <= gen_q;
    end
    if (cmd_i.mem_read) begin
      rl_q  <= light_mem[IDX_W'(pidx_q)];
      rh_q  <= health_mem[IDX_W'(pidx_q)];
      rz_q  <= height_mem[IDX_W'(pidx_q)];
      rg_q  <= gen_mem[IDX_W'(pidx_q)];
      rok_q <= CNT_W'(pidx_q) < count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      lmin_q  <= 32'sh7FFF_FFFF;
      lmax_q  <= 32'sh8000_0000;
      hmin_q  <= 32'sh7FFF_FFFF;
      hmax_q  <= 32'sh8000_0000;
      zmin_q  <= 32'sh7FFF_FFFF;
      zmax_q  <= 32'sh8000_0000;
      gmin_q  <= 16'hFFFF;
      gmax_q  <= 16'h0000;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      lmin_q  <= 32'sh7FFF_FFFF;
      lmax_q  <= 32'sh8000_0000;
      hmin_q  <= 32'sh7FFF_FFFF;
      hmax_q  <= 32'sh8000_0000;
      zmin_q  <= 32'sh7FFF_FFFF;
      zmax_q  <= 32'sh8000_0000;
      gmin_q  <= 16'hFFFF;
      gmax_q  <= 16'h0000;
    end else if (cmd_i.load_commit) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + CNT_W'(1);
        if (en_l_q) begin
          if (light_q < lmin_q) lmin_q <= light_q;
          if (light_q > lmax_q) lmax_q <= light_q;
        end
        if (en_h_q) begin
          if (health < hmin_q) hmin_q <= health;
          if (health > hmax_q) hmax_q <= health;
        end
        if (en_z_q) begin
          if (hz_q < zmin_q) zmin_q <= hz_q;
          if (hz_q > zmax_q) zmax_q <= hz_q;
        end
        if (en_g_q) begin
          if (gen_q < gmin_q) gmin_q <= gen_q;
          if (gen_q > gmax_q) gmax_q <= gen_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_start) begin
      use_div_q <= div_start;
      if (rok_q && has_c && (num >= span) && (num > 34'sd0)) begin
        norm_q[cmd_i.chan] <= NORM_W'(65536);
      end else begin
        norm_q[cmd_i.chan] <= '0;
      end
    end else if (cmd_i.norm_capture && use_div_q) begin
      norm_q[cmd_i.chan] <= {1'b0, quot[15:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (cmd_i.publish) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      odata_q <= {7'b0, ovf_q, has_g, has_z, has_h, has_l,
                  norm_q[3], norm_q[2], norm_q[1], norm_q[0]};
      ostat_q <= !rok_q;
    end
  end

  assign out_valid_o  = oval_q;
  assign out_data_o   = odata_q;
  assign out_status_o = ostat_q;

endmodule

/* src/point_attribute_minmax_normalizer.sv */
// Top level of the point attribute min-max normalizer.
// Depends on pamn_pkg, pamn_ctrl and pamn_datapath.
//
// Usage:
//   s_axis carries one command per transaction; tuser holds the action
//   (clear, load one point, read one point), tdata the point fields.
//   m_axis returns one transaction for every read: four Q1.16 norms,
//   the has flags and the overflow flag in tdata, read_status in tuser.
//   cfg writes enables and the range epsilon by register index; it is
//   always ready. The user must write it only while the block is idle;
//   the block itself does not enforce this.
// Sequence:
//   clear is done at dispatch; load runs dispatch with the health
//   division, division wait and commit; read runs store read, four range
//   divisions on the one shared divider and output (a channel that needs
//   no division skips the divider wait). One command is worked at a time;
//   s_axis_tready is high in idle.
// Reset: counts, ranges and flags clear at once; point stores hold
//   nothing valid until loaded. A stalled m_axis holds its result and
//   the next command is still accepted; a following read waits for it.
module point_attribute_minmax_normalizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] point_index, [41:10] light_level, [73:42] ethylene,
  // [89:74] age_senescence, [105:90] light_senescence, [137:106] height_z,
  // [153:138] generation_level, [159:154] zero
  input  logic [pamn_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [16:0] light_norm, [33:17] health_norm, [50:34] height_norm,
  // [67:51] generation_norm, [68] has_light, [69] has_health,
  // [70] has_height, [71] has_generation, [72] overflowed, [79:73] zero
  output logic [pamn_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] read_status
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import pamn_pkg::*;

  pamn_cmd_t cmd;
  pamn_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pamn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pamn_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

/* src/pamn_checker.sv */
// Port-level checks on the normalizer result channel, bound to the top level.
// Depends on pamn_pkg.
module pamn_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pamn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import pamn_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'h10000 && m_axis_tdata[33:17] <= 17'h10000
      && m_axis_tdata[50:34] <= 17'h10000 && m_axis_tdata[67:51] <= 17'h10000)
    else $error("norm above one");

  a_unloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[67:0] == 68'd0)
    else $error("unloaded read with nonzero norm");

  a_norange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[68] |-> m_axis_tdata[16:0] == 17'd0)
    else $error("light norm without range");

endmodule

bind point_attribute_minmax_normalizer pamn_checker u_pamn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/pamn_checker.sv */
// Scoreboard for the point attribute min-max normalizer: watches the command,
// result and register channels, predicts every read and compares the fields.
// Depends on pamn_pkg.
module pamn_scoreboard (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [pamn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [pamn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import pamn_pkg::*;

  typedef struct {
    longint norm [4];
    bit     has [4];
    bit     status;
    bit     ovf;
  } norm_point_t;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  bit          en_light = 1, en_health = 1, en_height = 1, en_gen = 1;
  longint      epsilon = 7;
  longint      light_st [MAX_POINTS];
  longint      health_st [MAX_POINTS];
  longint      height_st [MAX_POINTS];
  longint      gen_st [MAX_POINTS];
  int unsigned n_points;
  longint      lo [4];
  longint      hi [4];
  bit          ovf_flag;
  norm_point_t expected_reads [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_reads.size();

  function automatic void clear_ranges();
    n_points = 0;
    for (int c = 0; c < 3; c++) begin
      lo[c] = I32_MAX;
      hi[c] = I32_MIN;
    end
    lo[CH_GEN] = 65535;
    hi[CH_GEN] = 0;
    ovf_flag   = 0;
  endfunction

  function automatic longint health_of(longint eth, longint age, longint lsen);
    longint dv;
    longint h;
    dv = ((age > lsen) ? age : lsen) + 1;
    h  = 65536 - eth / dv;
    return (h < I32_MIN) ? I32_MIN : h;
  endfunction

  function automatic longint unit_map(longint v, longint l, longint h);
    longint num;
    longint span;
    num  = v - l;
    span = h - l;
    if (num <= 0 || span <= 0) return 0;
    if (num >= span) return 65536;
    return (num * 65536) / span;
  endfunction

  function automatic void widen(int c, longint v);
    if (v < lo[c]) lo[c] = v;
    if (v > hi[c]) hi[c] = v;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endfunction

  initial clear_ranges();

  always @(posedge clk_i) begin
    longint      lt, hz, gv, hv;
    int unsigned idx;
    norm_point_t np;
    bit          en [4];
    longint      vals [4];
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_EN_LIGHT:  en_light  = cfg_data_i[0];
          REG_EN_HEALTH: en_health = cfg_data_i[0];
          REG_EN_HEIGHT: en_height = cfg_data_i[0];
          REG_EN_GEN:    en_gen    = cfg_data_i[0];
          REG_EPSILON:   epsilon   = longint'(cfg_data_i);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          ACT_CLEAR: clear_ranges();
          ACT_LOAD: begin
            lt = longint'($signed(s_axis_tdata[41:10]));
            hv = health_of(longint'(s_axis_tdata[73:42]), longint'(s_axis_tdata[89:74]),
                           longint'(s_axis_tdata[105:90]));
            hz = longint'($signed(s_axis_tdata[137:106]));
            gv = longint'(s_axis_tdata[153:138]);
            if (n_points >= MAX_POINTS) begin
              ovf_flag = 1;
            end else begin
              light_st[n_points]  = lt;
              health_st[n_points] = hv;
              height_st[n_points] = hz;
              gen_st[n_points]    = gv;
              n_points++;
              if (en_light)  widen(CH_LIGHT, lt);
              if (en_health) widen(CH_HEALTH, hv);
              if (en_height) widen(CH_HEIGHT, hz);
              if (en_gen)    widen(CH_GEN, gv);
            end
          end
          ACT_READ: begin
            idx = 32'(s_axis_tdata[9:0]);
            en  = '{en_light, en_health, en_height, en_gen};
            for (int c = 0; c < 4; c++) begin
              if (c == CH_GEN) np.has[c] = en[c] && (hi[c] * 65536 - lo[c] * 65536 > epsilon);
              else np.has[c] = en[c] && (hi[c] - lo[c] > epsilon);
              np.norm[c] = 0;
            end
            np.status = 1;
            np.ovf    = ovf_flag;
            if (idx < n_points) begin
              np.status = 0;
              vals = '{light_st[idx], health_st[idx], height_st[idx], gen_st[idx]};
              for (int c = 0; c < 4; c++)
                if (np.has[c]) np.norm[c] = unit_map(vals[c], lo[c], hi[c]);
            end
            expected_reads.push_back(np);
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reads.size() == 0) begin
          $error("result transaction with no read outstanding");
          fails++;
        end else begin
          np = expected_reads.pop_front();
          check_field("light_norm", np.norm[0], m_axis_tdata[16:0]);
          check_field("health_norm", np.norm[1], m_axis_tdata[33:17]);
          check_field("height_norm", np.norm[2], m_axis_tdata[50:34]);
          check_field("generation_norm", np.norm[3], m_axis_tdata[67:51]);
          check_field("has_light", np.has[0], m_axis_tdata[68]);
          check_field("has_health", np.has[1], m_axis_tdata[69]);
          check_field("has_height", np.has[2], m_axis_tdata[70]);
          check_field("has_generation", np.has[3], m_axis_tdata[71]);
          check_field("overflowed", np.ovf, m_axis_tdata[72]);
          check_field("read_status", np.status, m_axis_tuser);
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the point attribute min-max normalizer: drives
// commands and register writes, stalls the result side, and watches progress.
// Depends on pamn_pkg, pamn_scoreboard and the block itself.
module tb_top;
  import pamn_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 120;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = ACT_CLEAR;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i = REG_EN_LIGHT;
  logic [15:0]           cfg_data_i = '0;
  int                    fail_count;
  int                    pending;
  int                    loaded;
  bit                    send_calm;
  int                    quiet_cycles;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  point_attribute_minmax_normalizer dut (.*);

  pamn_scoreboard u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, one calm window, one long hold-off
  initial begin
    int results;
    int hold;
    results = 0;
    hold    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (results == 40 && hold == 0) hold = 3000;
      if (hold > 1) begin
        m_axis_tready <= 0;
        hold--;
      end else if (results >= 100 && results < 160) begin
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 38);
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) results++;
    end
  end

  task automatic send(logic [1:0] act, logic [9:0] idx, logic [31:0] light,
                      logic [31:0] eth, logic [15:0] age, logic [15:0] lsen,
                      logic [31:0] hz, logic [15:0] gen);
    while (!send_calm && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'd0, gen, hz, lsen, age, eth, light, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (act == ACT_CLEAR) loaded = 0;
    else if (act == ACT_LOAD && loaded < MAX_POINTS) loaded++;
  endtask

  task automatic load_point(logic [31:0] light, logic [31:0] eth, logic [15:0] age,
                            logic [15:0] lsen, logic [31:0] hz, logic [15:0] gen);
    send(ACT_LOAD, 10'($urandom), light, eth, age, lsen, hz, gen);
  endtask

  task automatic read_point(logic [9:0] idx);
    send(ACT_READ, idx, $urandom, $urandom, 16'($urandom), 16'($urandom), $urandom,
         16'($urandom));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic cfg_all(bit l, bit h, bit z, bit g, logic [15:0] eps);
    cfg_write(REG_EN_LIGHT, {15'd0, l});
    cfg_write(REG_EN_HEALTH, {15'd0, h});
    cfg_write(REG_EN_HEIGHT, {15'd0, z});
    cfg_write(REG_EN_GEN, {15'd0, g});
    cfg_write(REG_EPSILON, eps);
  endtask

  function automatic logic [31:0] pick_fixed();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 4000) - 2000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 655360);
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    return $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12));
  endfunction

  function automatic logic [15:0] pick_eps();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_index();
    if (loaded > 0 && $urandom_range(0, 4) != 0) return 10'($urandom_range(0, loaded - 1));
    return 10'($urandom);
  endfunction

  initial begin
    send_calm = 0;
    loaded    = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: extremes, every action, saturated health, unloaded and empty reads
    read_point(10'd0);
    load_point(32'h8000_0000, 32'hFFFF_FFFF, 16'd0, 16'd0, 32'h8000_0000, 16'd0);
    load_point(32'h7FFF_FFFF, 32'd0, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF);
    load_point(32'd0, 32'h0001_0000, 16'd1, 16'd3, 32'd0, 16'd7);
    read_point(10'd0);
    read_point(10'd1);
    read_point(10'd2);
    read_point(10'h3FF);
    send(ACT_IGNORED, 10'd1, $urandom, $urandom, 16'($urandom), 16'($urandom), $urandom,
         16'($urandom));
    read_point(10'd3);
    send(ACT_CLEAR, 10'd0, '0, '0, '0, '0, '0, '0);
    read_point(10'd0);
    load_point(32'd5, 32'd0, 16'd0, 16'd0, 32'd5, 16'd2);
    load_point(32'd12, 32'd0, 16'd0, 16'd0, 32'd13, 16'd2);
    read_point(10'd1);
    wait_idle();

    // enables dropped after loading, then the widest epsilon on an empty set
    cfg_all(0, 0, 0, 0, 16'd0);
    read_point(10'd0);
    load_point(32'd100, 32'd9, 16'd2, 16'd1, 32'd100, 16'd9);
    read_point(10'd2);
    wait_idle();
    cfg_all(1, 1, 1, 1, 16'hFFFF);
    send(ACT_CLEAR, 10'd0, '0, '0, '0, '0, '0, '0);
    read_point(10'h3FF);
    read_point(10'd0);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      cfg_all(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), pick_eps());
      if (ph == 0) cfg_all(1, 1, 1, 1, 16'd0);
      if ($urandom_range(0, 2) != 0) send(ACT_CLEAR, 10'd0, '0, '0, '0, '0, '0, '0);
      for (int k = 0; k < 85; k++) begin
        int r;
        r = $urandom_range(0, 99);
        send_calm = (ph == 3);
        if (r < 3) send(ACT_CLEAR, 10'd0, $urandom, $urandom, '0, '0, '0, '0);
        else if (r < 7) send(ACT_IGNORED, 10'($urandom), $urandom, $urandom,
                             16'($urandom), 16'($urandom), $urandom, 16'($urandom));
        else if (r < 55) load_point(pick_fixed(),
                                    $urandom_range(0, 1) ? 32'($urandom) :
                                    32'($urandom_range(0, 200000)),
                                    pick_count(), pick_count(), pick_fixed(), pick_count());
        else read_point(pick_index());
      end
      send_calm = 0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
